// ----- sv/bpa_pkg.sv -----
// ============================================================================
// bpa_pkg
// Shared types and constants of the bitmap page allocator: result codes,
// opcode values, bitmap word geometry and the controller/datapath bundles.
// ============================================================================
package bpa_pkg;

    // Address and register geometry
    localparam int ADDR_W  = 48;
    localparam int PDATA_W = 64;
    localparam int PADDR_W = 4;

    // Bitmap is held as rows of WORD_W used bits
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    // Register index, taken from paddr[3]
    localparam logic REG_POOL_BASE = 1'b0;

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_BADFREE = 2'd2
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    capture;
        logic    ram_rd;
        logic    row_inc;
        logic    check_load;
        logic    ram_wr;
        logic    res_load;
        status_t res_code;
        logic    out_load;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_free;
        logic out_of_range;
        logic found;
        logic bit_set;
        logic last_row;
        logic out_full;
    } stat_t;

endpackage

// ----- sv/bpa_ifs.sv -----
// ============================================================================
// bpa_ifs
// Request and response channels of the bitmap page allocator, each a
// valid/ready handshake with its payload.
// ============================================================================
interface bpa_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [47:0] free_addr;

    modport source (output valid, output op, output free_addr, input ready);
    modport sink   (input valid, input op, input free_addr, output ready);
endinterface

interface bpa_rsp_if;
    logic        valid;
    logic        ready;
    logic [47:0] page_addr;
    logic [1:0]  status;

    modport source (output valid, output page_addr, output status, input ready);
    modport sink   (input valid, input page_addr, input status, output ready);
endinterface

// ----- sv/bpa_ram.sv -----
// ============================================================================
// bpa_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/bpa_dp.sv -----
// ============================================================================
// bpa_dp
// Datapath of the page allocator: request capture, bitmap RAM with per-row
// valid bits, free-bit search, page address arithmetic and result register.
// ============================================================================
module bpa_dp #(
    parameter int POOL_PAGES = 64,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [bpa_pkg::ADDR_W-1:0] pool_base,
    input  logic                       req_op,
    input  logic [bpa_pkg::ADDR_W-1:0] req_free_addr,
    input  logic                       rsp_ready,
    output logic                       rsp_valid,
    output logic [bpa_pkg::ADDR_W-1:0] rsp_page_addr,
    output logic [1:0]                 rsp_status,
    input  bpa_pkg::cmd_t              cmd,
    output bpa_pkg::stat_t             stat
);

    localparam int ADDR_W    = bpa_pkg::ADDR_W;
    localparam int WORD_W    = bpa_pkg::WORD_W;
    localparam int BIT_W     = bpa_pkg::BIT_W;
    localparam int ROWS      = (POOL_PAGES + WORD_W - 1) / WORD_W;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PIDX_W    = ROW_W + BIT_W;
    localparam int IDX_W     = ADDR_W - PAGE_SHIFT;
    localparam int LAST_BITS = POOL_PAGES - (ROWS - 1) * WORD_W;
    localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);

    logic                  op_reg;
    logic [ADDR_W-1:0]     off_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [BIT_W-1:0]      bit_reg;
    logic [WORD_W-1:0]     wr_word_reg;
    logic [ROWS-1:0]       row_valid_reg;
    logic [ADDR_W-1:0]     res_addr_reg;
    bpa_pkg::status_t      res_status_reg;
    logic                  out_valid_reg;
    logic [ADDR_W-1:0]     out_addr_reg;
    bpa_pkg::status_t      out_status_reg;

    logic [ADDR_W-1:0]     base_al;
    logic [PIDX_W-1:0]     off_pidx;
    logic [ROW_W-1:0]      off_row;
    logic [BIT_W-1:0]      off_bit;
    logic [ROW_W-1:0]      cur_row;
    logic [WORD_W-1:0]     rd_data;
    logic [WORD_W-1:0]     word;
    logic [WORD_W-1:0]     row_mask;
    logic [WORD_W-1:0]     avail;
    logic [BIT_W-1:0]      found_bit;
    logic [ADDR_W-1:0]     alloc_addr;

    // Page-aligned pool base
    assign base_al = {pool_base[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

    // Page index of the freed address, split into row and bit
    assign off_pidx = off_reg[PAGE_SHIFT +: PIDX_W];
    assign off_row  = off_pidx[PIDX_W-1:BIT_W];
    assign off_bit  = off_pidx[BIT_W-1:0];
    assign cur_row  = (op_reg == bpa_pkg::OP_FREE) ? off_row : row_reg;

    // Bitmap storage, one row per RAM word
    bpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_bitmap (
        .clk   (clk),
        .we    (cmd.ram_wr),
        .waddr (cur_row),
        .wdata (wr_word_reg),
        .re    (cmd.ram_rd),
        .raddr (cur_row),
        .rdata (rd_data)
    );

    // A row never written reads as all pages free
    assign word     = row_valid_reg[cur_row] ? rd_data : '0;
    assign row_mask = (cur_row == ROW_W'(ROWS - 1)) ? LAST_MASK : '1;
    assign avail    = ~word & row_mask;

    // Lowest free page within the row
    always_comb
    begin
        found_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                found_bit = BIT_W'(i);
            end
        end
    end

    assign alloc_addr = base_al + (ADDR_W'({row_reg, bit_reg}) << PAGE_SHIFT);

    // Status towards the controller
    assign stat.is_free      = (op_reg == bpa_pkg::OP_FREE);
    assign stat.out_of_range = off_reg[ADDR_W-1:PAGE_SHIFT] >= IDX_W'(POOL_PAGES);
    assign stat.found        = |avail;
    assign stat.bit_set      = word[off_bit];
    assign stat.last_row     = (row_reg == ROW_W'(ROWS - 1));
    assign stat.out_full     = out_valid_reg && !rsp_ready;

    // Request capture, row scan and bitmap update word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= req_op;
            off_reg <= req_free_addr - base_al;
            row_reg <= '0;
        end
        else if (cmd.row_inc)
        begin
            row_reg <= row_reg + 1'b1;
        end

        if (cmd.check_load)
        begin
            if (op_reg == bpa_pkg::OP_FREE)
            begin
                bit_reg     <= off_bit;
                wr_word_reg <= word & ~(WORD_W'(1) << off_bit);
            end
            else
            begin
                bit_reg     <= found_bit;
                wr_word_reg <= word | (WORD_W'(1) << found_bit);
            end
        end

        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_code;
            if (cmd.res_code == bpa_pkg::ST_OK && op_reg == bpa_pkg::OP_ALLOC)
            begin
                res_addr_reg <= alloc_addr;
            end
            else
            begin
                res_addr_reg <= '0;
            end
        end

        if (cmd.out_load)
        begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // Row valid bits: cleared at reset, set on first write of a row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (cmd.ram_wr)
        begin
            row_valid_reg[cur_row] <= 1'b1;
        end
    end

    // Output register valid: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign rsp_page_addr = out_addr_reg;
    assign rsp_status    = out_status_reg;

    // Checks
    a_no_rd_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ram_rd && cmd.ram_wr))
        else $error("bitmap RAM read and write in the same cycle");

    a_nomem_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != bpa_pkg::ST_OK) |-> (out_addr_reg == '0))
        else $error("failed request carries a non-zero page address");

    a_row_valid_after_wr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ram_wr |=> row_valid_reg[$past(cur_row)])
        else $error("written bitmap row not marked valid");

endmodule

// ----- sv/bpa_ctrl.sv -----
// ============================================================================
// bpa_ctrl
// Controller of the page allocator: sequences request capture, the bitmap
// row scan, the bitmap update and the hand-over to the output register.
// ============================================================================
module bpa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  bpa_pkg::stat_t stat,
    output bpa_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_CHECK = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.res_code = bpa_pkg::ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                if (stat.is_free && stat.out_of_range)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = bpa_pkg::ST_BADFREE;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.ram_rd = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check_load = 1'b1;
                if (stat.is_free)
                begin
                    if (stat.bit_set)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = bpa_pkg::ST_BADFREE;
                        state_next   = S_DONE;
                    end
                end
                else if (stat.found)
                begin
                    state_next = S_WRITE;
                end
                else if (stat.last_row)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = bpa_pkg::ST_NOMEM;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.row_inc = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_WRITE:
            begin
                cmd.ram_wr   = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_code = bpa_pkg::ST_OK;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_ready = (state_reg == S_IDLE);

    // Checks
    a_double_free_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK && stat.is_free && !stat.bit_set) |=> (state_reg == S_DONE))
        else $error("free of an unused page did not end the request");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !stat.out_full)
        else $error("result loaded over one not yet taken");

    a_write_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |=> (state_reg == S_DONE))
        else $error("bitmap write not followed by result hand-over");

endmodule

// ----- sv/bitmap_page_allocator.sv -----
// ============================================================================
// bitmap_page_allocator
// Page pool allocator with one used bit per page and lowest-free-first
// allocation; top level with the pool base register.
// ============================================================================
// Usage: a request on req carries op (0 allocate, 1 free) and free_addr.
// Each request gives one response on rsp: page_addr and status (0 ok,
// 1 no free page, 2 invalid free). pool_base is written over the APB port
// at byte address 0 while no request is in flight; its low PAGE_SHIFT bits
// are ignored.
// Timing: one request is handled at a time. The bitmap is read one row of
// 32 pages at a time (RAM read, then search), from row 0 until an allocate
// finds its page or the last row is searched and a full pool is reported.
// A free reads only its own row and writes it back only when the page is in
// use; a free outside the pool skips the RAM read. req is ready again
// the cycle after the result moves into the output register.
// Reset: all pages become free at once through per-row valid bits, and the
// pool base returns to 0; no clearing pass runs.
// Stall: the output register holds a response until rsp.ready; a finished
// request waits there while the next one is accepted and worked on, and
// that one's result waits until the register is free.
// ============================================================================
module bitmap_page_allocator #(
    parameter int POOL_PAGES = 64,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    bpa_req_if.sink                     req,
    bpa_rsp_if.source                   rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpa_pkg::PADDR_W-1:0] paddr,
    input  logic [bpa_pkg::PDATA_W-1:0] pwdata,
    output logic [bpa_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int ADDR_W = bpa_pkg::ADDR_W;

    logic [ADDR_W-1:0] pool_base_reg;
    logic              cfg_wr;
    bpa_pkg::cmd_t     cmd;
    bpa_pkg::stat_t    stat;

    // Register write on the APB access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
        end
        else if (cfg_wr && paddr[3] == bpa_pkg::REG_POOL_BASE)
        begin
            pool_base_reg <= pwdata[ADDR_W-1:0];
        end
    end

    // Register read-back
    assign prdata = (paddr[3] == bpa_pkg::REG_POOL_BASE)
                  ? {{(bpa_pkg::PDATA_W - ADDR_W){1'b0}}, pool_base_reg}
                  : '0;

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bpa_dp #(
        .POOL_PAGES (POOL_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .pool_base     (pool_base_reg),
        .req_op        (req.op),
        .req_free_addr (req.free_addr),
        .rsp_ready     (rsp.ready),
        .rsp_valid     (rsp.valid),
        .rsp_page_addr (rsp.page_addr),
        .rsp_status    (rsp.status),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

// ----- tb/tb_bitmap_page_allocator.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_bitmap_page_allocator
// Self-checking bench for the page pool allocator. A bitmap tracker follows
// every accepted allocate or free request and predicts the page address and
// status. Responses are compared in order against that prediction. Stimulus
// is a short directed opening, then phases of fill and drain traffic under
// several pool bases, with random gaps on both channels.
// ============================================================================
module tb_bitmap_page_allocator;

    localparam int ADDR_W       = bpa_pkg::ADDR_W;
    localparam int PADDR_W      = bpa_pkg::PADDR_W;
    localparam int PDATA_W      = bpa_pkg::PDATA_W;
    localparam int POOL_PAGES   = 64;
    localparam int PAGE_SHIFT   = 12;
    localparam int PHASE_ITEMS  = 248;
    localparam int NUM_PHASES   = 7;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic [ADDR_W-1:0] page_addr;
        bpa_pkg::status_t  status;
    } page_rsp_t;

    // Tracks the used bitmap and the pool base, and holds the responses due
    class pool_tracker;
        logic [POOL_PAGES-1:0] used;
        logic [ADDR_W-1:0]     base;
        page_rsp_t             pending[$];
        int mismatches;
        int checked;
        int n_alloc;
        int n_free;
        int n_nomem;
        int n_badfree;
        int n_wrap;

        function new();
            used       = '0;
            base       = '0;
            mismatches = 0;
            checked    = 0;
            n_alloc    = 0;
            n_free     = 0;
            n_nomem    = 0;
            n_badfree  = 0;
            n_wrap     = 0;
        endfunction

        // Drop the in-page offset bits of a new base
        function void set_base(logic [ADDR_W-1:0] value);
            base = {value[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
        endfunction

        // Pick a page with the wanted used bit, starting at a random index
        function int pick_page(bit want_used);
            int start;
            int j;
            start = $urandom_range(0, POOL_PAGES - 1);
            for (int i = 0; i < POOL_PAGES; i++)
            begin
                j = (start + i) % POOL_PAGES;
                if (used[j] == want_used)
                    return j;
            end
            return -1;
        endfunction

        // Apply one accepted request to the bitmap and queue its response
        function void note_request(logic op, logic [ADDR_W-1:0] addr);
            page_rsp_t       rsp_due;
            logic [ADDR_W:0] sum;
            logic [ADDR_W-1:0] offs;
            int              idx;
            bit              found;
            rsp_due.page_addr = '0;
            rsp_due.status    = bpa_pkg::ST_OK;
            found             = 1'b0;
            if (op == bpa_pkg::OP_ALLOC)
            begin
                n_alloc++;
                for (int k = 0; k < POOL_PAGES && !found; k++)
                begin
                    if (!used[k])
                    begin
                        used[k] = 1'b1;
                        sum = {1'b0, base} + ((ADDR_W + 1)'(k) << PAGE_SHIFT);
                        rsp_due.page_addr = sum[ADDR_W-1:0];
                        if (sum[ADDR_W])
                            n_wrap++;
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    rsp_due.status = bpa_pkg::ST_NOMEM;
                    n_nomem++;
                end
            end
            else
            begin
                n_free++;
                offs = addr - base;
                if ((offs >> PAGE_SHIFT) >= POOL_PAGES)
                    rsp_due.status = bpa_pkg::ST_BADFREE;
                else
                begin
                    idx = int'(offs >> PAGE_SHIFT);
                    if (!used[idx])
                        rsp_due.status = bpa_pkg::ST_BADFREE;
                    else
                        used[idx] = 1'b0;
                end
                if (rsp_due.status == bpa_pkg::ST_BADFREE)
                    n_badfree++;
            end
            pending.push_back(rsp_due);
        endfunction

        // Compare one response with the oldest one due
        function void check_response(logic [ADDR_W-1:0] page_addr,
                                     logic [1:0] status);
            page_rsp_t exp_rsp;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: response with no request outstanding: addr %h status %0d",
                             $realtime, page_addr, status);
                return;
            end
            exp_rsp = pending.pop_front();
            if (page_addr !== exp_rsp.page_addr || status !== exp_rsp.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch: expected addr %h status %0d, %s %h status %0d",
                             $realtime, exp_rsp.page_addr, exp_rsp.status, "got addr",
                             page_addr, status);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();

    pool_tracker tracker = new();

    bit calm_tx = 1'b0;
    bit calm_rx = 1'b0;
    int base_writes = 0;

    bitmap_page_allocator i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long ones
    function int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function logic [ADDR_W-1:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    // Choose a free address: mostly pages in use, plus double frees and strays
    function logic [ADDR_W-1:0] free_target();
        logic [PAGE_SHIFT-1:0] off;
        int kind;
        int idx;
        off  = PAGE_SHIFT'($urandom);
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            idx = tracker.pick_page(kind < 60);
            if (idx < 0)
                idx = tracker.pick_page(!(kind < 60));
            return tracker.base + (ADDR_W'(idx) << PAGE_SHIFT) + ADDR_W'(off);
        end
        else if (kind < 80)
            return rand48();
        else if (kind < 90)
            return tracker.base - ADDR_W'($urandom_range(1, 1 << 16));
        else
            return tracker.base + (ADDR_W'(POOL_PAGES + $urandom_range(0, 3)) << PAGE_SHIFT)
                   + ADDR_W'(off);
    endfunction

    // Present one request and hold it until accepted
    task automatic send_request(logic op, logic [ADDR_W-1:0] addr);
        int gap;
        gap = pick_gap(calm_tx);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.op        <= op;
        req_ch.free_addr <= addr;
        do
            @(posedge clk);
        while (!req_ch.ready);
        tracker.note_request(op, addr);
    endtask

    // Stop sending until every response due has been taken
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending.size() != 0);
    endtask

    task automatic wait_idle();
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(logic reg_idx, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == bpa_pkg::REG_POOL_BASE)
        begin
            tracker.set_base(value[ADDR_W-1:0]);
            base_writes++;
        end
    endtask

    // Alternate between filling the pool and draining it, with stray frees
    task automatic random_phase(int n_items);
        bit fill;
        int in_use;
        fill = 1'b1;
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                calm_tx = !calm_tx;
            if (i == n_items / 2 || $urandom_range(0, 299) == 0)
                hold_until_drained();
            in_use = $countones(tracker.used);
            if (in_use == POOL_PAGES && $urandom_range(0, 3) == 0)
                fill = 1'b0;
            else if (in_use == 0 && $urandom_range(0, 3) == 0)
                fill = 1'b1;
            else if ($urandom_range(0, 99) == 0)
                fill = !fill;
            if ($urandom_range(0, 99) < (fill ? 75 : 25))
                send_request(bpa_pkg::OP_ALLOC, rand48());
            else
                send_request(bpa_pkg::OP_FREE, free_target());
        end
    endtask

    function logic [PDATA_W-1:0] phase_base(int phase);
        case (phase)
            0: return '1;
            1: return '0;
            2: return {$urandom, $urandom};
            3: return {16'h0000, 32'hFFFF_FFFE, 4'h0, 12'($urandom)};
            4: return 64'h0000_0000_0000_1FFF;
            5: return {16'h0000, rand48()};
            default: return {$urandom, 16'h0, 16'($urandom)};
        endcase
    endfunction

    // Response side: random back-pressure, check every response taken
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                calm_rx = !calm_rx;
            stall = pick_gap(calm_rx);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            tracker.check_response(rsp_ch.page_addr, rsp_ch.status);
        end
    end

    // Main sequence
    initial
    begin
        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.op        <= bpa_pkg::OP_ALLOC;
        req_ch.free_addr <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening with the base at its reset value
        send_request(bpa_pkg::OP_FREE, 48'h0);
        send_request(bpa_pkg::OP_ALLOC, '1);
        send_request(bpa_pkg::OP_ALLOC, '0);
        send_request(bpa_pkg::OP_ALLOC, rand48());
        send_request(bpa_pkg::OP_FREE, 48'h1FFF);
        send_request(bpa_pkg::OP_FREE, 48'h1000);
        send_request(bpa_pkg::OP_ALLOC, '0);
        send_request(bpa_pkg::OP_FREE, 48'h4_0000);
        send_request(bpa_pkg::OP_FREE, 48'h3_FFFF);
        send_request(bpa_pkg::OP_FREE, '1);
        send_request(bpa_pkg::OP_FREE, 48'h2ABC);
        wait_idle();

        // Unaligned base, then frees below, inside and past the pool
        write_reg(bpa_pkg::REG_POOL_BASE, 64'h0000_8000_0000_5A5A);
        send_request(bpa_pkg::OP_FREE, 48'h8000_0000_4FFF);
        send_request(bpa_pkg::OP_FREE, 48'h0);
        send_request(bpa_pkg::OP_ALLOC, rand48());
        send_request(bpa_pkg::OP_FREE, 48'h8000_0000_6FFF);
        send_request(bpa_pkg::OP_ALLOC, rand48());
        send_request(bpa_pkg::OP_FREE, 48'h8000_0004_5000);

        // Random phases under a series of bases
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            write_reg(bpa_pkg::REG_POOL_BASE, phase_base(p));
            if (p == 3)
                write_reg(~bpa_pkg::REG_POOL_BASE, {$urandom, $urandom});
            random_phase(PHASE_ITEMS);
        end

        wait_idle();
        $display("Covered %0d allocates (%0d with the pool full, %0d wrapped addresses)",
                 tracker.n_alloc, tracker.n_nomem, tracker.n_wrap);
        $display("and %0d frees (%0d rejected); checked %0d responses under %0d bases, %0d %s",
                 tracker.n_free, tracker.n_badfree, tracker.checked, base_writes,
                 tracker.mismatches, "mismatches.");
        if (tracker.mismatches == 0 && tracker.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(10_000_000);
        $display("Timeout with %0d responses outstanding", tracker.pending.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
